/* rtl/msp_pkg.sv */
// shared widths, reset values, register index codes and payload structs
// for the mecanum wheel speed solver; no dependencies
package msp_pkg;

   localparam int WHEELS      = 4;
   localparam int SPEED_W     = 24;
   localparam int ARM_W       = 16;
   localparam int GAIN_W      = 24;
   localparam int GAIN_HALF_W = GAIN_W / 2;
   localparam int RPM_LIM_W   = 15;
   localparam int RPM_W       = 16;
   localparam int LIN_W       = SPEED_W + 2;
   localparam int SUM_W       = 41;
   localparam int MAG_W       = SUM_W;
   localparam int PROD_W      = MAG_W + GAIN_HALF_W;
   localparam int TOT_W       = PROD_W + 1;
   localparam int RPM_SHIFT   = 24;
   localparam int Q_W         = TOT_W - RPM_SHIFT;
   localparam int QUO_W       = RPM_LIM_W;
   localparam int NUM_W       = RPM_W + RPM_LIM_W;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [ARM_W-1:0]     FRONT_ARM_RESET = ARM_W'(1638);
   localparam logic [ARM_W-1:0]     REAR_ARM_RESET  = ARM_W'(1638);
   localparam logic [GAIN_W-1:0]    GAIN_RESET      = GAIN_W'(9830400);
   localparam logic [RPM_LIM_W-1:0] MAX_RPM_RESET   = RPM_LIM_W'(8000);

   localparam logic [RPM_W-1:0] MAG_POS_MAX = RPM_W'(32767);
   localparam logic [RPM_W-1:0] MAG_NEG_MAX = RPM_W'(32768);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRONT_ARM = 3'd0,
      CSR_REAR_ARM  = 3'd1,
      CSR_GAIN      = 3'd2,
      CSR_MAX_RPM   = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic [WHEELS-1:0]            neg;
      logic [WHEELS-1:0][MAG_W-1:0] mag;
   } msp_sum_type;

   typedef struct packed {
      logic [WHEELS-1:0]            neg;
      logic [WHEELS-1:0][RPM_W-1:0] mag;
   } msp_wheel_type;

   typedef struct packed {
      logic                         scale;
      logic [RPM_W-1:0]             peak;
      logic [WHEELS-1:0]            neg;
      logic [WHEELS-1:0][RPM_W-1:0] mag;
      logic [WHEELS-1:0][NUM_W-1:0] num;
   } msp_lim_type;

   function automatic logic [RPM_W-1:0] max_mag(input logic [RPM_W-1:0] a,
                                                input logic [RPM_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic [RPM_W-1:0] abs_rpm(input logic [RPM_W-1:0] w);
      return w[RPM_W-1] ? RPM_W'(-w) : w;
   endfunction

endpackage

/* rtl/msp_kin.sv */
// wheel kinematics: linear terms, turn terms, per-wheel sum and magnitude
// three register stages; depends on msp_pkg
module msp_kin import msp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic signed [SPEED_W-1:0] forward_speed,
   input  logic signed [SPEED_W-1:0] lateral_speed,
   input  logic signed [SPEED_W-1:0] turn_rate,
   input  logic [ARM_W-1:0]          front_arm,
   input  logic [ARM_W-1:0]          rear_arm,
   output logic                      out_valid,
   input  logic                      out_ready,
   output msp_sum_type               out_data
);

   localparam int N = 3;

   logic [N-1:0] vld_ff;
   logic [N-1:0] vld_in;
   logic [N-1:0] adv;

   logic signed [LIN_W-1:0] vx_e;
   logic signed [LIN_W-1:0] vy_e;
   logic signed [LIN_W-1:0] lin_in [WHEELS];
   logic signed [LIN_W-1:0] lin_ff [WHEELS];
   logic signed [SUM_W-1:0] tf_in;
   logic signed [SUM_W-1:0] tb_in;
   logic signed [SUM_W-1:0] tf_ff;
   logic signed [SUM_W-1:0] tb_ff;
   logic signed [SUM_W-1:0] sum_in [WHEELS];
   logic signed [SUM_W-1:0] sum_ff [WHEELS];
   logic [MAG_W-1:0]        mag_in [WHEELS];
   logic [MAG_W-1:0]        mag_ff [WHEELS];
   logic [WHEELS-1:0]       neg_in;
   logic [WHEELS-1:0]       neg_ff;

   always_comb begin
      adv[N-1] = !vld_ff[N-1] || out_ready;
      for (int i = N - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
   end

   assign vld_in   = {vld_ff[N-2:0], in_valid};
   assign in_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < N; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   // stage 1: linear combinations and turn products
   assign vx_e = {{2{forward_speed[SPEED_W-1]}}, forward_speed};
   assign vy_e = {{2{lateral_speed[SPEED_W-1]}}, lateral_speed};
   assign lin_in[0] = vy_e - vx_e;
   assign lin_in[1] = vy_e + vx_e;
   assign lin_in[2] = -vy_e - vx_e;
   assign lin_in[3] = -vy_e + vx_e;
   assign tf_in = turn_rate * $signed({1'b0, front_arm});
   assign tb_in = turn_rate * $signed({1'b0, rear_arm});

   // stage 2: align linear term to 24 fraction bits and add turn term
   // stage 3: sign and magnitude
   always_comb begin
      for (int i = 0; i < WHEELS; i++) begin
         sum_in[i] = $signed({{(SUM_W - LIN_W - 12){lin_ff[i][LIN_W-1]}}, lin_ff[i], 12'b0})
                   + ((i < 2) ? tf_ff : tb_ff);
         neg_in[i] = sum_ff[i][SUM_W-1];
         mag_in[i] = sum_ff[i][SUM_W-1] ? (~sum_ff[i] + MAG_W'(1)) : sum_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         lin_ff <= lin_in;
         tf_ff  <= tf_in;
         tb_ff  <= tb_in;
      end
      if (adv[1]) begin
         sum_ff <= sum_in;
      end
      if (adv[2]) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
   end

   always_comb begin
      out_data.neg = neg_ff;
      for (int i = 0; i < WHEELS; i++) begin
         out_data.mag[i] = mag_ff[i];
      end
   end

   assign out_valid = vld_ff[N-1];

endmodule

/* rtl/msp_rpm.sv */
// rpm scaling: magnitude times gain in two halves, truncation, saturation
// two register stages; depends on msp_pkg
module msp_rpm import msp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  msp_sum_type         in_data,
   input  logic [GAIN_W-1:0]   gain,
   output logic                out_valid,
   input  logic                out_ready,
   output msp_wheel_type       out_data
);

   localparam int N = 2;

   logic [N-1:0] vld_ff;
   logic [N-1:0] vld_in;
   logic [N-1:0] adv;

   logic [GAIN_HALF_W-1:0] ghi;
   logic [GAIN_HALF_W-1:0] glo;
   logic [PROD_W-1:0]      p_hi_in [WHEELS];
   logic [PROD_W-1:0]      p_lo_in [WHEELS];
   logic [PROD_W-1:0]      p_hi_ff [WHEELS];
   logic [PROD_W-1:0]      p_lo_ff [WHEELS];
   logic [WHEELS-1:0]      neg_ff;
   logic [TOT_W-1:0]       tot [WHEELS];
   logic [Q_W-1:0]         q [WHEELS];
   msp_wheel_type          wheel_in;
   msp_wheel_type          wheel_ff;

   always_comb begin
      adv[N-1] = !vld_ff[N-1] || out_ready;
      for (int i = N - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
   end

   assign vld_in   = {vld_ff[N-2:0], in_valid};
   assign in_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < N; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   assign ghi = gain[GAIN_W-1:GAIN_HALF_W];
   assign glo = gain[GAIN_HALF_W-1:0];

   always_comb begin
      wheel_in.neg = neg_ff;
      for (int i = 0; i < WHEELS; i++) begin
         p_hi_in[i] = in_data.mag[i] * ghi;
         p_lo_in[i] = in_data.mag[i] * glo;
         tot[i] = {1'b0, p_hi_ff[i]}
                + {{(GAIN_HALF_W + 1){1'b0}}, p_lo_ff[i][PROD_W-1:GAIN_HALF_W]};
         q[i] = tot[i][TOT_W-1:RPM_SHIFT];
         if (neg_ff[i]) begin
            wheel_in.mag[i] = (q[i] > Q_W'(MAG_NEG_MAX)) ? MAG_NEG_MAX : q[i][RPM_W-1:0];
         end else begin
            wheel_in.mag[i] = (q[i] > Q_W'(MAG_POS_MAX)) ? MAG_POS_MAX : q[i][RPM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         p_hi_ff <= p_hi_in;
         p_lo_ff <= p_lo_in;
         neg_ff  <= in_data.neg;
      end
      if (adv[1]) begin
         wheel_ff <= wheel_in;
      end
   end

   assign out_data  = wheel_ff;
   assign out_valid = vld_ff[N-1];

endmodule

/* rtl/msp_lim.sv */
// limit check: peak magnitude tree, limit compare, scaled numerators
// two register stages; depends on msp_pkg
module msp_lim import msp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  msp_wheel_type        in_data,
   input  logic [RPM_LIM_W-1:0] max_rpm,
   output logic                 out_valid,
   input  logic                 out_ready,
   output msp_lim_type          out_data
);

   localparam int N = 2;

   logic [N-1:0] vld_ff;
   logic [N-1:0] vld_in;
   logic [N-1:0] adv;

   logic [RPM_W-1:0]             pair_in [2];
   logic [RPM_W-1:0]             pair_ff [2];
   logic [WHEELS-1:0][NUM_W-1:0] num_in;
   logic [WHEELS-1:0][NUM_W-1:0] num_ff;
   msp_wheel_type                wheel_ff;
   msp_lim_type                  lim_in;
   msp_lim_type                  lim_ff;

   always_comb begin
      adv[N-1] = !vld_ff[N-1] || out_ready;
      for (int i = N - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
   end

   assign vld_in   = {vld_ff[N-2:0], in_valid};
   assign in_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < N; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   always_comb begin
      pair_in[0] = max_mag(in_data.mag[0], in_data.mag[1]);
      pair_in[1] = max_mag(in_data.mag[2], in_data.mag[3]);
      for (int i = 0; i < WHEELS; i++) begin
         num_in[i] = in_data.mag[i] * max_rpm;
      end
   end

   always_comb begin
      lim_in.peak  = max_mag(pair_ff[0], pair_ff[1]);
      lim_in.scale = lim_in.peak > {1'b0, max_rpm};
      lim_in.neg   = wheel_ff.neg;
      lim_in.mag   = wheel_ff.mag;
      lim_in.num   = num_ff;
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         pair_ff  <= pair_in;
         num_ff   <= num_in;
         wheel_ff <= in_data;
      end
      if (adv[1]) begin
         lim_ff <= lim_in;
      end
   end

   assign out_data  = lim_ff;
   assign out_valid = vld_ff[N-1];

`ifndef SYNTHESIS
   a_peak_covers_all: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (lim_ff.mag[0] <= lim_ff.peak) && (lim_ff.mag[1] <= lim_ff.peak)
                 && (lim_ff.mag[2] <= lim_ff.peak) && (lim_ff.mag[3] <= lim_ff.peak))
      else $error("wheel magnitude above peak");
`endif

endmodule

/* rtl/msp_div.sv */
// pipelined restoring divider, one quotient bit per stage, four lanes,
// followed by the signed output register; depends on msp_pkg
module msp_div import msp_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  msp_lim_type                  in_data,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [WHEELS-1:0][RPM_W-1:0] rpm
);

   localparam int N = QUO_W + 1;

   typedef struct packed {
      logic                         scale;
      logic [RPM_W-1:0]             dvs;
      logic [WHEELS-1:0]            neg;
      logic [WHEELS-1:0][RPM_W-1:0] mag;
      logic [WHEELS-1:0][RPM_W-1:0] rem;
      logic [WHEELS-1:0][QUO_W-1:0] quo;
   } div_stage_type;

   function automatic div_stage_type div_step(input div_stage_type s);
      div_stage_type  r;
      logic [RPM_W:0] t;
      r = s;
      for (int i = 0; i < WHEELS; i++) begin
         t = {s.rem[i], s.quo[i][QUO_W-1]};
         if (t >= {1'b0, s.dvs}) begin
            r.rem[i] = RPM_W'(t - {1'b0, s.dvs});
            r.quo[i] = {s.quo[i][QUO_W-2:0], 1'b1};
         end else begin
            r.rem[i] = t[RPM_W-1:0];
            r.quo[i] = {s.quo[i][QUO_W-2:0], 1'b0};
         end
      end
      return r;
   endfunction

   logic [N-1:0] vld_ff;
   logic [N-1:0] vld_in;
   logic [N-1:0] adv;

   div_stage_type                first;
   div_stage_type                div_in [QUO_W];
   div_stage_type                div_ff [QUO_W];
   logic [WHEELS-1:0][RPM_W-1:0] sel;
   logic [WHEELS-1:0][RPM_W-1:0] rpm_in;
   logic [WHEELS-1:0][RPM_W-1:0] rpm_ff;

   always_comb begin
      adv[N-1] = !vld_ff[N-1] || out_ready;
      for (int i = N - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
   end

   assign vld_in   = {vld_ff[N-2:0], in_valid};
   assign in_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < N; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   // numerator high part is below the divisor, so 15 steps give the quotient
   always_comb begin
      first.scale = in_data.scale;
      first.dvs   = in_data.peak;
      first.neg   = in_data.neg;
      first.mag   = in_data.mag;
      for (int i = 0; i < WHEELS; i++) begin
         first.rem[i] = in_data.num[i][NUM_W-1:QUO_W];
         first.quo[i] = in_data.num[i][QUO_W-1:0];
      end
      div_in[0] = div_step(first);
      for (int k = 1; k < QUO_W; k++) begin
         div_in[k] = div_step(div_ff[k-1]);
      end
   end

   always_comb begin
      for (int i = 0; i < WHEELS; i++) begin
         sel[i] = div_ff[QUO_W-1].scale ? {1'b0, div_ff[QUO_W-1].quo[i]}
                                        : div_ff[QUO_W-1].mag[i];
         rpm_in[i] = div_ff[QUO_W-1].neg[i] ? RPM_W'(-sel[i]) : sel[i];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < QUO_W; k++) begin
         if (adv[k]) begin
            div_ff[k] <= div_in[k];
         end
      end
      if (adv[N-1]) begin
         rpm_ff <= rpm_in;
      end
   end

   assign rpm       = rpm_ff;
   assign out_valid = vld_ff[N-1];

endmodule

/* rtl/mecanum_wheel_speed_solver.sv */
// mecanum wheel speed solver: usage
// req channel: one chassis command per transfer (forward, lateral, turn rate,
// signed Q11.12); rsp channel: four wheel setpoints in rpm, one per command.
// csr channel: register writes by index, always ready; write only while idle.
// stages from a req transfer to its rsp transfer: kinematics 3, rpm scaling 2,
// limit check 2, 15 divider steps, output 1.
// throughput: one command per cycle while rsp is not stalled; the 15-stage
// divider and the gain multipliers are fully pipelined.
// reset clears every stage valid bit and loads the register defaults.
// when rsp_ready is low the last stage holds; bubbles behind it close up and
// req_ready drops only once every stage holds a command.
// depends on msp_pkg, msp_kin, msp_rpm, msp_lim, msp_div
module mecanum_wheel_speed_solver import msp_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [SPEED_W-1:0]    req_forward_speed,
   input  logic signed [SPEED_W-1:0]    req_lateral_speed,
   input  logic signed [SPEED_W-1:0]    req_turn_rate,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [RPM_W-1:0]      rsp_right_front_rpm,
   output logic signed [RPM_W-1:0]      rsp_left_front_rpm,
   output logic signed [RPM_W-1:0]      rsp_right_back_rpm,
   output logic signed [RPM_W-1:0]      rsp_left_back_rpm,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_INDEX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_data
);

   logic [ARM_W-1:0]     front_arm_ff;
   logic [ARM_W-1:0]     rear_arm_ff;
   logic [GAIN_W-1:0]    gain_ff;
   logic [RPM_LIM_W-1:0] max_rpm_ff;

   logic                         kin_valid;
   logic                         kin_ready;
   msp_sum_type                  kin_data;
   logic                         rpm_valid;
   logic                         rpm_ready;
   msp_wheel_type                rpm_data;
   logic                         lim_valid;
   logic                         lim_ready;
   msp_lim_type                  lim_data;
   logic [WHEELS-1:0][RPM_W-1:0] div_rpm;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_arm_ff <= FRONT_ARM_RESET;
         rear_arm_ff  <= REAR_ARM_RESET;
         gain_ff      <= GAIN_RESET;
         max_rpm_ff   <= MAX_RPM_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FRONT_ARM: front_arm_ff <= csr_data[ARM_W-1:0];
            CSR_REAR_ARM:  rear_arm_ff  <= csr_data[ARM_W-1:0];
            CSR_GAIN:      gain_ff      <= csr_data[GAIN_W-1:0];
            CSR_MAX_RPM:   max_rpm_ff   <= csr_data[RPM_LIM_W-1:0];
            default: ;
         endcase
      end
   end

   msp_kin u_kin (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .forward_speed (req_forward_speed),
      .lateral_speed (req_lateral_speed),
      .turn_rate     (req_turn_rate),
      .front_arm     (front_arm_ff),
      .rear_arm      (rear_arm_ff),
      .out_valid     (kin_valid),
      .out_ready     (kin_ready),
      .out_data      (kin_data)
   );

   msp_rpm u_rpm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (kin_valid),
      .in_ready  (kin_ready),
      .in_data   (kin_data),
      .gain      (gain_ff),
      .out_valid (rpm_valid),
      .out_ready (rpm_ready),
      .out_data  (rpm_data)
   );

   msp_lim u_lim (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rpm_valid),
      .in_ready  (rpm_ready),
      .in_data   (rpm_data),
      .max_rpm   (max_rpm_ff),
      .out_valid (lim_valid),
      .out_ready (lim_ready),
      .out_data  (lim_data)
   );

   msp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (lim_valid),
      .in_ready  (lim_ready),
      .in_data   (lim_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .rpm       (div_rpm)
   );

   assign rsp_right_front_rpm = div_rpm[0];
   assign rsp_left_front_rpm  = div_rpm[1];
   assign rsp_right_back_rpm  = div_rpm[2];
   assign rsp_left_back_rpm   = div_rpm[3];

`ifndef SYNTHESIS
   a_stall_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled while output not blocked");

   a_front_within_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (abs_rpm(rsp_right_front_rpm) <= {1'b0, max_rpm_ff})
                 && (abs_rpm(rsp_left_front_rpm) <= {1'b0, max_rpm_ff}))
      else $error("front wheel above rpm limit");

   a_back_within_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (abs_rpm(rsp_right_back_rpm) <= {1'b0, max_rpm_ff})
                 && (abs_rpm(rsp_left_back_rpm) <= {1'b0, max_rpm_ff}))
      else $error("back wheel above rpm limit");
`endif

endmodule

/* bench/wheel_rpm_checker.sv */
// setpoint checker: watches the command, result and register channels of
// mecanum_wheel_speed_solver, predicts the four wheel setpoints and compares them
// depends on msp_pkg
`timescale 1ns / 100ps

module setpoint_checker import msp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic signed [SPEED_W-1:0] req_forward_speed,
   input  logic signed [SPEED_W-1:0] req_lateral_speed,
   input  logic signed [SPEED_W-1:0] req_turn_rate,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic signed [RPM_W-1:0]   rsp_right_front_rpm,
   input  logic signed [RPM_W-1:0]   rsp_left_front_rpm,
   input  logic signed [RPM_W-1:0]   rsp_right_back_rpm,
   input  logic signed [RPM_W-1:0]   rsp_left_back_rpm,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data,
   output int                        in_flight,
   output int                        mismatches
);

   typedef struct packed {
      logic signed [RPM_W-1:0] right_front;
      logic signed [RPM_W-1:0] left_front;
      logic signed [RPM_W-1:0] right_back;
      logic signed [RPM_W-1:0] left_back;
   } wheel_set_type;

   logic [ARM_W-1:0]     front_arm;
   logic [ARM_W-1:0]     rear_arm;
   logic [GAIN_W-1:0]    rpm_gain;
   logic [RPM_LIM_W-1:0] rpm_limit;

   wheel_set_type expected_rpm_q[$];

   // sum carries 24 fraction bits; gain applied in two halves, truncated toward zero
   function automatic int rpm_from_sum(input longint sum);
      longint unsigned mag;
      longint unsigned whole;
      mag = (sum < 0) ? -sum : sum;
      whole = (mag * rpm_gain[GAIN_W-1:GAIN_HALF_W]
               + ((mag * rpm_gain[GAIN_HALF_W-1:0]) >> GAIN_HALF_W)) >> RPM_SHIFT;
      if (sum < 0) begin
         return (whole > MAG_NEG_MAX) ? -int'(MAG_NEG_MAX) : -int'(whole);
      end
      return (whole > MAG_POS_MAX) ? int'(MAG_POS_MAX) : int'(whole);
   endfunction

   function automatic wheel_set_type solve_wheels(
      input logic signed [SPEED_W-1:0] fwd,
      input logic signed [SPEED_W-1:0] lat,
      input logic signed [SPEED_W-1:0] turn);
      longint            vx;
      longint            vy;
      longint            vw;
      longint            lin[WHEELS];
      longint            arm_term;
      int                wheel[WHEELS];
      int                mag;
      int                peak;
      wheel_set_type     result;
      vx = fwd;
      vy = lat;
      vw = turn;
      lin[0] = vy - vx;
      lin[1] = vy + vx;
      lin[2] = -vy - vx;
      lin[3] = -vy + vx;
      peak = 0;
      for (int i = 0; i < WHEELS; i++) begin
         arm_term = (i < 2) ? vw * longint'(front_arm) : vw * longint'(rear_arm);
         wheel[i] = rpm_from_sum(lin[i] * 4096 + arm_term);
         mag = (wheel[i] < 0) ? -wheel[i] : wheel[i];
         if (mag > peak) peak = mag;
      end
      // scale all four by limit / peak so the direction is kept
      if (peak > int'(rpm_limit)) begin
         for (int i = 0; i < WHEELS; i++) begin
            mag = (wheel[i] < 0) ? -wheel[i] : wheel[i];
            mag = mag * int'(rpm_limit) / peak;
            wheel[i] = (wheel[i] < 0) ? -mag : mag;
         end
      end
      result.right_front = RPM_W'(wheel[0]);
      result.left_front  = RPM_W'(wheel[1]);
      result.right_back  = RPM_W'(wheel[2]);
      result.left_back   = RPM_W'(wheel[3]);
      return result;
   endfunction

   task automatic compare_wheels(input wheel_set_type want);
      wheel_set_type got;
      got.right_front = rsp_right_front_rpm;
      got.left_front  = rsp_left_front_rpm;
      got.right_back  = rsp_right_back_rpm;
      got.left_back   = rsp_left_back_rpm;
      if (got !== want) begin
         mismatches++;
         $display("%0t ns: rpm mismatch rf/lf/rb/lb expected %0d %0d %0d %0d,",
                  $time, want.right_front, want.left_front, want.right_back,
                  want.left_back, " got %0d %0d %0d %0d", got.right_front,
                  got.left_front, got.right_back, got.left_back);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         front_arm = FRONT_ARM_RESET;
         rear_arm  = REAR_ARM_RESET;
         rpm_gain  = GAIN_RESET;
         rpm_limit = MAX_RPM_RESET;
         expected_rpm_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_FRONT_ARM: front_arm = csr_data[ARM_W-1:0];
               CSR_REAR_ARM:  rear_arm  = csr_data[ARM_W-1:0];
               CSR_GAIN:      rpm_gain  = csr_data[GAIN_W-1:0];
               CSR_MAX_RPM:   rpm_limit = csr_data[RPM_LIM_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rpm_q.size() == 0) begin
               mismatches++;
               $display("%0t ns: result transfer with no command outstanding,",
                        $time, " got %0d %0d %0d %0d", rsp_right_front_rpm,
                        rsp_left_front_rpm, rsp_right_back_rpm, rsp_left_back_rpm);
            end else begin
               compare_wheels(expected_rpm_q.pop_front());
            end
         end
         if (req_valid && req_ready) begin
            expected_rpm_q.push_back(solve_wheels(req_forward_speed, req_lateral_speed,
                                                  req_turn_rate));
         end
      end
      in_flight <= expected_rpm_q.size();
   end

endmodule

/* bench/tb.sv */
// testbench top for mecanum_wheel_speed_solver: clock, reset, command and
// register stimulus, result stalls and the verdict
// depends on msp_pkg, setpoint_checker and the solver rtl
`timescale 1ns / 100ps

module tb import msp_pkg::*;;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   localparam int CSR_COUNT      = 4;
   localparam int PHASES         = 8;
   localparam int PHASE_COMMANDS = 85;
   localparam int DRAIN_CYCLES   = 30;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic signed [SPEED_W-1:0] req_forward_speed;
   logic signed [SPEED_W-1:0] req_lateral_speed;
   logic signed [SPEED_W-1:0] req_turn_rate;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [RPM_W-1:0]   rsp_right_front_rpm;
   logic signed [RPM_W-1:0]   rsp_left_front_rpm;
   logic signed [RPM_W-1:0]   rsp_right_back_rpm;
   logic signed [RPM_W-1:0]   rsp_left_back_rpm;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]     csr_data;
   int                        in_flight;
   int                        mismatches;
   int                        send_idle_pct = 0;
   int                        stall_pct = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   mecanum_wheel_speed_solver u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_forward_speed   (req_forward_speed),
      .req_lateral_speed   (req_lateral_speed),
      .req_turn_rate       (req_turn_rate),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_right_front_rpm (rsp_right_front_rpm),
      .rsp_left_front_rpm  (rsp_left_front_rpm),
      .rsp_right_back_rpm  (rsp_right_back_rpm),
      .rsp_left_back_rpm   (rsp_left_back_rpm),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   setpoint_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_forward_speed   (req_forward_speed),
      .req_lateral_speed   (req_lateral_speed),
      .req_turn_rate       (req_turn_rate),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_right_front_rpm (rsp_right_front_rpm),
      .rsp_left_front_rpm  (rsp_left_front_rpm),
      .rsp_right_back_rpm  (rsp_right_back_rpm),
      .rsp_left_back_rpm   (rsp_left_back_rpm),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .in_flight           (in_flight),
      .mismatches          (mismatches)
   );

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic set_idle(input idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin send_idle_pct <= 0;  stall_pct <= 0;  end
         IDLE_SENDER:   begin send_idle_pct <= 75; stall_pct <= 0;  end
         IDLE_RECEIVER: begin send_idle_pct <= 0;  stall_pct <= 75; end
         default:       begin send_idle_pct <= 32; stall_pct <= 32; end
      endcase
   endtask

   // log-spread magnitude so small, mid and saturating speeds all show up
   function automatic logic signed [SPEED_W-1:0] pick_speed();
      logic [SPEED_W-1:0] raw;
      raw = SPEED_W'($urandom);
      if ($urandom_range(7) != 0) begin
         raw = raw >> $urandom_range(SPEED_W - 1);
         if ($urandom_range(1) != 0) raw = -raw;
      end
      return raw;
   endfunction

   task automatic send_command(input logic signed [SPEED_W-1:0] fwd,
                               input logic signed [SPEED_W-1:0] lat,
                               input logic signed [SPEED_W-1:0] turn);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_forward_speed <= fwd;
      req_lateral_speed <= lat;
      req_turn_rate     <= turn;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (in_flight != 0);
   endtask

   task automatic await_csr();
      do @(posedge clock); while (!csr_ready);
   endtask

   // all four registers, then a write to an unused index that must be ignored
   task automatic program_regs(input logic [ARM_W-1:0]     front,
                               input logic [ARM_W-1:0]     rear,
                               input logic [GAIN_W-1:0]    gain,
                               input logic [RPM_LIM_W-1:0] limit);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= CSR_FRONT_ARM;
      csr_data  <= CSR_DATA_W'(front);
      await_csr();
      csr_index <= CSR_REAR_ARM;
      csr_data  <= CSR_DATA_W'(rear);
      await_csr();
      csr_index <= CSR_GAIN;
      csr_data  <= CSR_DATA_W'(gain);
      await_csr();
      csr_index <= CSR_MAX_RPM;
      csr_data  <= CSR_DATA_W'(limit);
      await_csr();
      csr_index <= CSR_INDEX_W'($urandom_range(2 ** CSR_INDEX_W - 1, CSR_COUNT));
      csr_data  <= CSR_DATA_W'($urandom);
      await_csr();
      csr_valid <= 1'b0;
   endtask

   initial begin
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_forward_speed <= '0;
      req_lateral_speed <= '0;
      req_turn_rate     <= '0;
      csr_valid         <= 1'b0;
      csr_index         <= CSR_FRONT_ARM;
      csr_data          <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset register values
      send_command('0, '0, '0);
      send_command(SPEED_W'(8388607), SPEED_W'(8388607), SPEED_W'(8388607));
      send_command(SPEED_W'(-8388608), SPEED_W'(-8388608), SPEED_W'(-8388608));
      send_command(SPEED_W'(8388607), SPEED_W'(-8388608), '0);
      send_command(SPEED_W'(-8388608), SPEED_W'(8388607), SPEED_W'(8388607));
      send_command('0, '0, SPEED_W'(8388607));
      send_command('0, '0, SPEED_W'(-8388608));
      send_command(SPEED_W'(4096), '0, '0);
      send_command('0, SPEED_W'(-4096), SPEED_W'(-2048));
      send_command(SPEED_W'(-4097), SPEED_W'(1), SPEED_W'(-1));
      send_command(SPEED_W'(13653), '0, '0);
      send_command(SPEED_W'(13654), '0, '0);
      send_command(SPEED_W'(-13656), '0, '0);
      send_command(SPEED_W'(4096), SPEED_W'(4096), SPEED_W'(4096));
      send_command(SPEED_W'(1), SPEED_W'(-1), SPEED_W'(1));
      send_command(SPEED_W'(60000), SPEED_W'(-30000), SPEED_W'(10000));

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: program_regs(FRONT_ARM_RESET, REAR_ARM_RESET, GAIN_RESET, MAX_RPM_RESET);
            1: program_regs('0, '1, '1, RPM_LIM_W'(1));
            2: program_regs('1, '0, '0, '1);
            3: program_regs('1, '1, '1, '1);
            default: program_regs(ARM_W'($urandom), ARM_W'($urandom), GAIN_W'($urandom),
                                  RPM_LIM_W'($urandom_range(2 ** RPM_LIM_W - 1, 1)));
         endcase
         set_idle(idle_mode_type'(phase % 4));
         for (int n = 0; n < PHASE_COMMANDS; n++) begin
            if (n == PHASE_COMMANDS / 2) wait_drained();
            send_command(pick_speed(), pick_speed(), pick_speed());
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
